// ===== rtl/nllm_pkg.sv =====
package nllm_pkg;

  // field widths fixed by the item format
  localparam int RANK_W    = 10;
  localparam int NODE_ID_W = 7;
  localparam int OWN_NODE_W = 6;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;

  // counters stop here
  localparam logic [CNT_W-1:0] MAX_RANKS = 11'd1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE = 1'd1;

  // item modes; code 3 is unused and ignored
  typedef enum logic [1:0] {
    MODE_LEADER = 2'd0,
    MODE_MAP    = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]                  mode;
    logic [RANK_W-1:0]           rank;
    logic signed [NODE_ID_W-1:0] node_id;
  } in_item_t;

  typedef struct packed {
    logic             error;
    logic             new_leader;
    logic [IDX_W-1:0] leader_index;
    logic             same_node;
    logic [IDX_W-1:0] local_index;
    logic [IDX_W-1:0] map_rank;
    logic             map_is_local;
    logic [CNT_W-1:0] local_count;
    logic [CNT_W-1:0] leader_count;
  } result_t;

  // saturating count step
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v < MAX_RANKS) ? CNT_W'(v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/nllm_if.sv =====
// item channel into the block
interface nllm_in_if import nllm_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [RANK_W-1:0]           rank;
  logic signed [NODE_ID_W-1:0] node_id;

  modport source(output valid, mode, rank, node_id, input ready);
  modport sink(input valid, mode, rank, node_id, output ready);
endinterface

// result channel out of the block
interface nllm_out_if import nllm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             error;
  logic             new_leader;
  logic [IDX_W-1:0] leader_index;
  logic             same_node;
  logic [IDX_W-1:0] local_index;
  logic [IDX_W-1:0] map_rank;
  logic             map_is_local;
  logic [CNT_W-1:0] local_count;
  logic [CNT_W-1:0] leader_count;

  modport source(output valid, error, new_leader, leader_index, same_node, local_index,
                 map_rank, map_is_local, local_count, leader_count, input ready);
  modport sink(input valid, error, new_leader, leader_index, same_node, local_index,
               map_rank, map_is_local, local_count, leader_count, output ready);
endinterface

// ===== rtl/node_leader_local_mapper_top.sv =====
// Node leader / local mapper. Takes (mode, rank, node_id) items and returns one
// result per item: leader assignment in mode 0, rank mapping in mode 1, and a
// full clear of the node table and counters in mode 2 (mode 3 is ignored).
// Throughput is one item per clock while out_ch is ready; each item passes the
// input register (with the leader-index RAM read beside it), then the result
// register. The RAM read is issued at input transfer; a write from the item
// ahead to the same node is forwarded. Backpressure from out_ch stalls the input
// register, which still takes a new item in the cycle the waiting result leaves.
// own_rank (index 0) and own_node (index 1) must be written through cfg_* only
// while no item is in flight (not enforced). No clearing pass after reset.
module node_leader_local_mapper_top import nllm_pkg::*; #(
  parameter int MAX_NODES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  nllm_in_if.sink              in_ch,
  nllm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  logic [RANK_W-1:0]     own_rank_r;
  logic [OWN_NODE_W-1:0] own_node_r;
  logic                  s1_valid_r;
  in_item_t              s1_item_r;
  logic                  byp_r;
  logic [IDX_W-1:0]      byp_data_r;
  logic                  out_valid_r;
  result_t               out_res_r;
  logic                  s1_adv;
  logic                  in_xfer;
  logic [NODE_W-1:0]     rd_addr;
  logic [IDX_W-1:0]      mem_rdata;
  logic [IDX_W-1:0]      rd_idx;
  result_t               res;
  logic                  mem_we;
  logic [NODE_W-1:0]     mem_waddr;
  logic [IDX_W-1:0]      mem_wdata;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_rank_r <= '0;
      own_node_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_RANK: own_rank_r <= cfg_wdata;
        CFG_OWN_NODE: own_node_r <= cfg_wdata[OWN_NODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: stage 1 moves when the result register is free or draining
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign rd_addr     = NODE_W'(in_ch.node_id[OWN_NODE_W-1:0]);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload and write forwarding for the RAM read issued at the same edge
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r  <= '{mode: in_ch.mode, rank: in_ch.rank, node_id: in_ch.node_id};
      byp_r      <= mem_we && (mem_waddr == rd_addr);
      byp_data_r <= mem_wdata;
    end
  end

  nllm_idx_mem #(
    .DEPTH(MAX_NODES),
    .AW   (NODE_W)
  ) u_idx_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (in_xfer),
    .raddr  (rd_addr),
    .rdata_r(mem_rdata)
  );

  assign rd_idx = byp_r ? byp_data_r : mem_rdata;

  nllm_core #(
    .MAX_NODES(MAX_NODES),
    .NODE_W   (NODE_W)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (s1_adv),
    .item     (s1_item_r),
    .rd_idx   (rd_idx),
    .own_rank (own_rank_r),
    .own_node (own_node_r),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.error        = out_res_r.error;
  assign out_ch.new_leader   = out_res_r.new_leader;
  assign out_ch.leader_index = out_res_r.leader_index;
  assign out_ch.same_node    = out_res_r.same_node;
  assign out_ch.local_index  = out_res_r.local_index;
  assign out_ch.map_rank     = out_res_r.map_rank;
  assign out_ch.map_is_local = out_res_r.map_is_local;
  assign out_ch.local_count  = out_res_r.local_count;
  assign out_ch.leader_count = out_res_r.leader_count;

endmodule

// ===== rtl/nllm_idx_mem.sv =====
// leader index per node: one write port, one registered read port
module nllm_idx_mem import nllm_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [IDX_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [IDX_W-1:0] rdata_r
);

  logic [IDX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nllm_core.sv =====
// per-item decision logic plus the node valid bits and running counters
module nllm_core import nllm_pkg::*; #(
  parameter int MAX_NODES = 64,
  parameter int NODE_W    = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  in_item_t              item,
  input  logic [IDX_W-1:0]      rd_idx,
  input  logic [RANK_W-1:0]     own_rank,
  input  logic [OWN_NODE_W-1:0] own_node,
  output result_t               res,
  output logic                  mem_we,
  output logic [NODE_W-1:0]     mem_waddr,
  output logic [IDX_W-1:0]      mem_wdata
);

  logic [MAX_NODES-1:0]  node_valid_r;
  logic [CNT_W-1:0]      leaders_r, leaders_nxt;
  logic [CNT_W-1:0]      locals_r, locals_nxt;
  logic                  own_lead_r, own_lead_nxt;
  logic                  clr;
  logic                  set_valid;
  logic [OWN_NODE_W-1:0] node6;
  logic                  bad;
  logic                  vld;
  logic [IDX_W-1:0]      leader_rd;

  // node decode: negative or past the table is an error
  assign node6     = item.node_id[OWN_NODE_W-1:0];
  assign bad       = item.node_id[NODE_ID_W-1] || (32'(node6) >= MAX_NODES);
  assign mem_waddr = NODE_W'(node6);
  assign vld       = node_valid_r[mem_waddr];
  assign leader_rd = vld ? rd_idx : '0;
  assign mem_wdata = leaders_r[IDX_W-1:0];

  always_comb begin
    res          = '0;
    leaders_nxt  = leaders_r;
    locals_nxt   = locals_r;
    own_lead_nxt = own_lead_r;
    clr          = 1'b0;
    set_valid    = 1'b0;
    case (item.mode)
      MODE_CLEAR: begin
        clr          = 1'b1;
        leaders_nxt  = '0;
        locals_nxt   = '0;
        own_lead_nxt = 1'b0;
      end
      MODE_LEADER: begin
        if (bad) begin
          res.error = 1'b1;
        end else if (!vld) begin
          // first rank on this node takes the next leader index
          set_valid        = 1'b1;
          res.new_leader   = 1'b1;
          res.leader_index = leaders_r[IDX_W-1:0];
          leaders_nxt      = sat_inc(leaders_r);
          if (item.rank == own_rank) begin
            own_lead_nxt = 1'b1;
          end
        end
      end
      MODE_MAP: begin
        if (bad) begin
          res.error = 1'b1;
        end else if (node6 == own_node) begin
          res.same_node   = 1'b1;
          res.local_index = locals_r[IDX_W-1:0];
          if (own_lead_r && (item.rank == own_rank)) begin
            res.map_rank = leader_rd;
          end else begin
            res.map_rank     = locals_r[IDX_W-1:0];
            res.map_is_local = 1'b1;
          end
          locals_nxt = sat_inc(locals_r);
        end else if (own_lead_r) begin
          res.map_rank = leader_rd;
        end else begin
          // remote rank, not leader: local rank 0
          res.map_is_local = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.local_count  = locals_nxt;
    res.leader_count = own_lead_nxt ? leaders_nxt : '0;
  end

  assign mem_we = adv && set_valid;

  // state commits only when the item moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_valid_r <= '0;
      leaders_r    <= '0;
      locals_r     <= '0;
      own_lead_r   <= 1'b0;
    end else if (adv) begin
      if (clr) begin
        node_valid_r <= '0;
      end else if (set_valid) begin
        node_valid_r[mem_waddr] <= 1'b1;
      end
      leaders_r  <= leaders_nxt;
      locals_r   <= locals_nxt;
      own_lead_r <= own_lead_nxt;
    end
  end

endmodule

// ===== rtl/nllm_checker.sv =====
// port-level checks on the result channel
module nllm_checker import nllm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic             error,
  input logic             new_leader,
  input logic [IDX_W-1:0] leader_index,
  input logic             same_node,
  input logic [IDX_W-1:0] map_rank,
  input logic             map_is_local,
  input logic [CNT_W-1:0] local_count,
  input logic [CNT_W-1:0] leader_count
);

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(leader_index) && $stable(map_rank)
      && $stable(local_count) && $stable(leader_count))
    else $error("stalled result changed");

  // a bad node id produces no leader or mapping
  a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error |-> !new_leader && !same_node && (map_rank == '0) && !map_is_local)
    else $error("error result carries data");

  // new leader index trails the leader count by one while own rank leads
  a_leader_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && new_leader && (leader_count != '0) && (leader_index != '0)
      |-> leader_index == IDX_W'(leader_count[IDX_W-1:0] - 1'b1))
    else $error("leader index out of step with leader count");

  // a same-node rank has been counted
  a_local_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && same_node |-> local_count != '0)
    else $error("same-node result with zero local count");

endmodule

bind node_leader_local_mapper_top nllm_checker u_nllm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .error       (out_ch.error),
  .new_leader  (out_ch.new_leader),
  .leader_index(out_ch.leader_index),
  .same_node   (out_ch.same_node),
  .map_rank    (out_ch.map_rank),
  .map_is_local(out_ch.map_is_local),
  .local_count (out_ch.local_count),
  .leader_count(out_ch.leader_count)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import nllm_pkg::*;

  localparam int TABLE_SIZE = 64;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int ITEMS_PER_EPOCH = 110;
  // mode code the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Expected-result store plus a private model of the node table and counters
  class leader_map_scoreboard;
    logic [RANK_W-1:0]     own_rank;
    logic [OWN_NODE_W-1:0] own_node;
    bit                    node_seen[TABLE_SIZE];
    logic [IDX_W-1:0]      node_lead[TABLE_SIZE];
    logic [CNT_W-1:0]      leaders;
    logic [CNT_W-1:0]      locals;
    bit                    own_leads;
    result_t               expected_maps[$];
    int                    fails;
    int                    checked;
    int                    error_results;
    int                    peak_locals;

    function new();
      own_rank = '0;
      own_node = '0;
      clear_table();
    endfunction

    function void clear_table();
      foreach (node_seen[i]) begin
        node_seen[i] = 1'b0;
        node_lead[i] = '0;
      end
      leaders = '0;
      locals = '0;
      own_leads = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == CFG_OWN_RANK) own_rank = data[RANK_W-1:0];
      else if (idx == CFG_OWN_NODE) own_node = data[OWN_NODE_W-1:0];
    endfunction

    // counters hold at the cap
    function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
      return (v == MAX_RANKS) ? v : v + 1'b1;
    endfunction

    // true when a mapping item would look up a node that has no leader yet
    function bit reads_unset(in_item_t it);
      int nid;
      nid = int'($signed(it.node_id));
      if (it.mode != MODE_MAP || nid < 0 || nid >= TABLE_SIZE) return 1'b0;
      if (!own_leads) return 1'b0;
      if (nid[OWN_NODE_W-1:0] == own_node && it.rank != own_rank) return 1'b0;
      return !node_seen[nid];
    endfunction

    // work out the result for one accepted item and queue it
    function void note_item(in_item_t it);
      result_t r;
      int nid;
      bit bad;
      int nd;
      r = '0;
      nid = int'($signed(it.node_id));
      bad = (nid < 0) || (nid >= TABLE_SIZE);
      nd = bad ? 0 : nid;
      case (it.mode)
        MODE_CLEAR: clear_table();
        MODE_LEADER: begin
          if (bad) begin
            r.error = 1'b1;
          end else if (!node_seen[nd]) begin
            node_seen[nd] = 1'b1;
            node_lead[nd] = leaders[IDX_W-1:0];
            r.new_leader = 1'b1;
            r.leader_index = leaders[IDX_W-1:0];
            leaders = count_up(leaders);
            if (it.rank == own_rank) own_leads = 1'b1;
          end
        end
        MODE_MAP: begin
          if (bad) begin
            r.error = 1'b1;
          end else if (nd[OWN_NODE_W-1:0] == own_node) begin
            r.same_node = 1'b1;
            r.local_index = locals[IDX_W-1:0];
            if (own_leads && it.rank == own_rank) begin
              r.map_rank = node_seen[nd] ? node_lead[nd] : '0;
            end else begin
              r.map_rank = locals[IDX_W-1:0];
              r.map_is_local = 1'b1;
            end
            locals = count_up(locals);
          end else if (own_leads) begin
            r.map_rank = node_seen[nd] ? node_lead[nd] : '0;
          end else begin
            r.map_is_local = 1'b1;
          end
        end
        default: ;
      endcase
      r.local_count = locals;
      r.leader_count = own_leads ? leaders : '0;
      if (r.error) error_results++;
      if (int'(locals) > peak_locals) peak_locals = int'(locals);
      expected_maps.push_back(r);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
        if (fails < MAX_REPORTS)
          $display("result %0d mismatch on %s: expected %0d, got %0d",
                   checked, field, want, seen);
        fails++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_maps.size() == 0) begin
        if (fails < MAX_REPORTS) $display("result %0d arrived with nothing expected", checked);
        fails++;
      end else begin
        want = expected_maps.pop_front();
        cmp("error", 32'(want.error), 32'(got.error));
        cmp("new_leader", 32'(want.new_leader), 32'(got.new_leader));
        cmp("leader_index", 32'(want.leader_index), 32'(got.leader_index));
        cmp("same_node", 32'(want.same_node), 32'(got.same_node));
        cmp("local_index", 32'(want.local_index), 32'(got.local_index));
        cmp("map_rank", 32'(want.map_rank), 32'(got.map_rank));
        cmp("map_is_local", 32'(want.map_is_local), 32'(got.map_is_local));
        cmp("local_count", 32'(want.local_count), 32'(got.local_count));
        cmp("leader_count", 32'(want.leader_count), 32'(got.leader_count));
      end
      checked++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  nllm_in_if  in_ch ();
  nllm_out_if out_ch ();

  leader_map_scoreboard sb = new();

  bit src_gaps;
  bit sink_gaps;
  int stall_cycles;
  int item_count;
  int mode_hits[4];
  int config_writes;
  int unsigned cycle_count;

  node_leader_local_mapper_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // result side: random ready bursts, plus long stalls on request
  initial begin : result_sink
    int gap;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        out_ch.ready <= 1'b0;
        stall_cycles--;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 9);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // check every result transfer
  always @(posedge clk) begin
    result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.error        = out_ch.error;
      got.new_leader   = out_ch.new_leader;
      got.leader_index = out_ch.leader_index;
      got.same_node    = out_ch.same_node;
      got.local_index  = out_ch.local_index;
      got.map_rank     = out_ch.map_rank;
      got.map_is_local = out_ch.map_is_local;
      got.local_count  = out_ch.local_count;
      got.leader_count = out_ch.leader_count;
      sb.check_result(got);
    end
  end

  function automatic in_item_t item_of(logic [1:0] m, int r, int n);
    in_item_t it;
    it.mode = m;
    it.rank = RANK_W'(r);
    it.node_id = NODE_ID_W'(n);
    return it;
  endfunction

  // offer one item and wait for its transfer; called on a rising edge
  task automatic send(input in_item_t item);
    in_item_t it;
    int gap;
    it = item;
    // never look up a node without a leader
    if (sb.reads_unset(it)) it.mode = MODE_LEADER;
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.mode    <= it.mode;
    in_ch.rank    <= it.rank;
    in_ch.node_id <= it.node_id;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_item(it);
    if (it.mode != MODE_UNUSED) item_count++;
    mode_hits[it.mode]++;
  endtask

  // stop offering and wait until every expected result is in
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_maps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write own_rank then own_node; block must be idle
  task automatic set_config(int rank_val, int node_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_RANK;
    cfg_wdata <= CFG_W'(rank_val);
    @(posedge clk);
    sb.write_reg(CFG_OWN_RANK, CFG_W'(rank_val));
    cfg_index <= CFG_OWN_NODE;
    cfg_wdata <= CFG_W'(node_val);
    @(posedge clk);
    sb.write_reg(CFG_OWN_NODE, CFG_W'(node_val));
    cfg_we <= 1'b0;
    config_writes++;
  endtask

  // one random sequence: mostly a leader pass then a mapping pass over a rank window
  task automatic run_round();
    int n;
    int nn;
    int base;
    int start;
    int node_of[40];
    in_item_t it;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any mode, any node id
      n = $urandom_range(3, 12);
      repeat (n) begin
        it.mode = 2'($urandom_range(0, 3));
        it.rank = RANK_W'($urandom);
        it.node_id = NODE_ID_W'($urandom);
        send(it);
      end
    end else begin
      if ($urandom_range(0, 3) != 0) send(item_of(MODE_CLEAR, $urandom, $urandom));
      n = $urandom_range(4, 40);
      nn = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
      base = $urandom_range(0, 63);
      start = $urandom_range(0, 1024 - n);
      if ($urandom_range(0, 1) == 1) begin
        // pull own rank into the window
        start = int'(sb.own_rank) - $urandom_range(0, n - 1);
        if (start < 0) start = 0;
        if (start > 1024 - n) start = 1024 - n;
      end
      for (int i = 0; i < n; i++) begin
        if (start + i == int'(sb.own_rank) && $urandom_range(0, 3) != 0)
          node_of[i] = int'(sb.own_node);
        else if ($urandom_range(0, 3) == 0)
          node_of[i] = int'(sb.own_node);
        else
          node_of[i] = (base + $urandom_range(0, nn - 1)) % TABLE_SIZE;
      end
      // leader pass
      for (int i = 0; i < n; i++) begin
        it = item_of(MODE_LEADER, start + i, node_of[i]);
        if ($urandom_range(0, 19) == 0) it.node_id = NODE_ID_W'($urandom_range(64, 127));
        send(it);
      end
      // mapping pass
      for (int i = 0; i < n; i++) begin
        it = item_of(MODE_MAP, start + i, node_of[i]);
        if ($urandom_range(0, 19) == 0) it.node_id = NODE_ID_W'($urandom_range(64, 127));
        send(it);
      end
    end
  endtask

  initial begin : stimulus
    int goal;
    bit held;
    bit paused;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.mode    <= '0;
    in_ch.rank    <= '0;
    in_ch.node_id <= '0;
    out_ch.ready  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_wdata     <= '0;
    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    stall_cycles = 0;
    held = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: own rank 5 on node 3
    set_config(5, 3);
    send(item_of(MODE_LEADER, 0, 0));
    send(item_of(MODE_LEADER, 1, 0));      // node already has a leader
    send(item_of(MODE_LEADER, 2, 63));
    send(item_of(MODE_LEADER, 5, 3));      // own rank becomes leader
    send(item_of(MODE_LEADER, 6, -1));     // unknown node
    send(item_of(MODE_LEADER, 7, -64));    // id outside table
    send(item_of(MODE_UNUSED, 8, 5));
    send(item_of(MODE_MAP, 0, 0));         // remote, mapped to its leader
    send(item_of(MODE_MAP, 3, 3));         // local
    send(item_of(MODE_MAP, 5, 3));         // own rank maps to its leader index
    send(item_of(MODE_MAP, 8, 3));
    send(item_of(MODE_MAP, 9, 63));
    send(item_of(MODE_MAP, 10, -1));       // bad node in mapping pass
    send(item_of(MODE_MAP, 1023, 63));
    send(item_of(MODE_CLEAR, 0, 0));
    send(item_of(MODE_LEADER, 1023, 63));
    send(item_of(MODE_LEADER, 4, 3));
    send(item_of(MODE_MAP, 0, 63));        // not leader: remote maps to local 0
    send(item_of(MODE_MAP, 5, 3));         // own rank, not leader: plain local
    send(item_of(MODE_MAP, 1, 10));
    send(item_of(MODE_UNUSED, 1023, -64));
    send(item_of(MODE_CLEAR, 1023, -1));
    settle();

    // random epochs, each under its own settings; the last one without gaps
    for (int ep = 0; ep < 5; ep++) begin
      case (ep)
        0: set_config(1023, 63);
        1: set_config(0, 0);
        default: set_config($urandom_range(0, 1023), $urandom_range(0, 63));
      endcase
      src_gaps = (ep < 4);
      sink_gaps = (ep < 4);
      goal = item_count + ITEMS_PER_EPOCH;
      while (item_count < goal) begin
        if (ep == 2 && !held) begin
          // long receiver stall while the sender keeps offering
          held = 1'b1;
          src_gaps = 1'b0;
          stall_cycles = 300;
          run_round();
          run_round();
          src_gaps = 1'b1;
        end else begin
          run_round();
        end
        if (ep == 1 && !paused && item_count > goal - ITEMS_PER_EPOCH / 2) begin
          // sender waits for the block to drain mid-epoch
          paused = 1'b1;
          settle();
        end
      end
      settle();
    end

    $display("covered %0d items: %0d leader, %0d map, %0d clear, %0d unused; %0d results checked",
             item_count, mode_hits[MODE_LEADER], mode_hits[MODE_MAP], mode_hits[MODE_CLEAR],
             mode_hits[MODE_UNUSED], sb.checked);
    $display("%0d bad-node results, %0d config settings, local count peaked at %0d",
             sb.error_results, config_writes, sb.peak_locals);
    if (sb.fails == 0 && sb.expected_maps.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/nllm_pkg.sv
rtl/nllm_if.sv
rtl/nllm_idx_mem.sv
rtl/nllm_core.sv
rtl/node_leader_local_mapper_top.sv
rtl/nllm_checker.sv
dv/testbench.sv
